[src/i2c_slave_register_buffer_assert.svh]
// Assertion macros shared by the register buffer RTL.
`ifndef I2C_SLAVE_REGISTER_BUFFER_ASSERT_SVH
`define I2C_SLAVE_REGISTER_BUFFER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define I2CRB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("register buffer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define I2CRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("register buffer assertion failed");

`endif

[src/i2crb_pkg.sv]
// Shared types and constants of the I2C target register buffer.
package i2crb_pkg;

  // Bus event codes carried by each request.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_SENT  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  // Byte loaded for transmission after the master answers with a nak.
  localparam logic [7:0] NAK_FILL = 8'hFF;

  // Control group from the sequencer to the store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[src/i2crb_store.sv]
// Byte store with per-entry valid bits and a registered read port.
module i2crb_store
  import i2crb_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mem_ctl_t      ctl_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rd_data_q;
  logic             rd_valid_q;

  // Valid bits: an entry reads as zero until it is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[addr_i];
      end
    end
  end

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_data_q : 8'h00;

endmodule

[src/i2c_slave_register_buffer.sv]
// Top level of the I2C target register buffer: event sequencer around the store.
// Start, stop, data write and nak put their result straight into the output register;
// a memory address byte or an ack reads the store, through its read register and ST_RD.
// Throughput: one request per cycle unless the output stalls; no request is taken in ST_RD.
// Reset clears the pointer, the transmit byte and all valid bits and sets the phase flags,
// so the whole store reads as zero at once; no clearing pass is needed.
`include "i2c_slave_register_buffer_assert.svh"

module i2c_slave_register_buffer
  import i2crb_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic       nak_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  typedef enum logic {
    ST_ACC,
    ST_RD
  } state_e;

  state_e        state_q;
  logic [AW-1:0] ptr_q, ptr_d, ptr_inc, mem_addr;
  logic          dev_q, dev_d, memph_q, memph_d;
  logic [7:0]    tx_q, tx_d, rd_data;
  logic          out_valid_q;
  logic          in_acc;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mod_tbl [256];

  // Constant table reducing a received address byte modulo the depth.
  for (genvar g = 0; g < 256; g++) begin : g_mod
    localparam int unsigned Rem = g % DEPTH;
    assign mod_tbl[g] = AW'(Rem);
  end

  // Handshake: one request at a time, and none while the result waits.
  assign in_stall_o = (state_q == ST_RD) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ptr_inc    = (ptr_q == PTR_LAST) ? '0 : ptr_q + AW'(1);

  // Event decode: next pointer, phase flags, transmit byte and store access.
  always_comb begin
    ptr_d          = ptr_q;
    dev_d          = dev_q;
    memph_d        = memph_q;
    tx_d           = tx_q;
    mem_addr       = ptr_q;
    mem_ctl.wr_en  = 1'b0;
    mem_ctl.rd_en  = 1'b0;
    if (in_acc) begin
      case (cmd_e'(cmd_i))
        CMD_START: begin
          dev_d = 1'b1;
        end
        CMD_RECV: begin
          if (dev_q) begin
            dev_d = 1'b0;
          end else if (memph_q) begin
            memph_d       = 1'b0;
            ptr_d         = mod_tbl[rx_byte_i];
            mem_addr      = mod_tbl[rx_byte_i];
            mem_ctl.rd_en = 1'b1;
          end else begin
            mem_ctl.wr_en = 1'b1;
            ptr_d         = ptr_inc;
          end
        end
        CMD_SENT: begin
          if (nak_i) begin
            tx_d = NAK_FILL;
          end else begin
            ptr_d         = ptr_inc;
            mem_addr      = ptr_inc;
            mem_ctl.rd_en = 1'b1;
          end
        end
        CMD_STOP: begin
          dev_d   = 1'b1;
          memph_d = 1'b1;
        end
        default: begin
          dev_d = dev_q;
        end
      endcase
    end
  end

  i2crb_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mem_ctl),
    .addr_i (mem_addr),
    .wdata_i(rx_byte_i),
    .rdata_o(rd_data)
  );

  // Sequencer state, pointer, phase flags and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      ptr_q       <= '0;
      dev_q       <= 1'b1;
      memph_q     <= 1'b1;
      tx_q        <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ptr_q   <= ptr_d;
        dev_q   <= dev_d;
        memph_q <= memph_d;
        tx_q    <= tx_d;
        if (mem_ctl.rd_en) begin
          state_q     <= ST_RD;
          out_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (state_q == ST_RD) begin
        tx_q        <= rd_data;
        out_valid_q <= 1'b1;
        state_q     <= ST_ACC;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;

  // Checks on the sequencer and the store access.
  `I2CRB_ASSERT_NEXT(a_read_enters_wait, in_acc && mem_ctl.rd_en, state_q == ST_RD)
  `I2CRB_ASSERT_NEXT(a_wait_gives_result, state_q == ST_RD, out_valid_o && state_q == ST_ACC)
  `I2CRB_ASSERT_IMPL(a_no_accept_in_wait, state_q == ST_RD, in_stall_o && !out_valid_o)
  `I2CRB_ASSERT_IMPL(a_single_access, mem_ctl.wr_en, !mem_ctl.rd_en)
  `I2CRB_ASSERT_IMPL(a_ptr_in_range, 1'b1, ptr_q <= PTR_LAST)

endmodule
